### hdl/teletext_attribute_decoder_core_defines.svh
// Assertion macros shared by the teletext attribute decoder RTL.
`ifndef TELETEXT_ATTRIBUTE_DECODER_CORE_DEFINES_SVH
`define TELETEXT_ATTRIBUTE_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTAD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttad check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TTAD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttad check failed");

`endif

### hdl/ttad_pkg.sv
// Types, constants and control codes of the teletext attribute decoder.
package ttad_pkg;

  localparam int unsigned CODE_W     = 7;
  localparam int unsigned COLOR_W    = 3;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned OUT_USER_W = 1;

  localparam logic [CODE_W-1:0]  CODE_MASK       = 7'h7f;
  localparam logic [CODE_W-1:0]  CODE_NORMAL_HT  = 7'd12;
  localparam logic [CODE_W-1:0]  CODE_DOUBLE_HT  = 7'd13;
  localparam logic [CODE_W-1:0]  CODE_MOSAIC_LO  = 7'd17;
  localparam logic [CODE_W-1:0]  CODE_MOSAIC_HI  = 7'd23;
  localparam logic [CODE_W-1:0]  CODE_ALPHA_LO   = 7'd1;
  localparam logic [CODE_W-1:0]  CODE_ALPHA_HI   = 7'd7;
  localparam logic [CODE_W-1:0]  CODE_CONTIG     = 7'd25;
  localparam logic [CODE_W-1:0]  CODE_SEPARATED  = 7'd26;
  localparam logic [CODE_W-1:0]  CODE_BLACK_BG   = 7'd28;
  localparam logic [CODE_W-1:0]  CODE_NEW_BG     = 7'd29;
  localparam logic [CODE_W-1:0]  CODE_HOLD_ON    = 7'd30;
  localparam logic [CODE_W-1:0]  CODE_HOLD_OFF   = 7'd31;
  localparam logic [CODE_W-1:0]  CODE_FIRST_CHAR = 7'd32;

  localparam logic [COLOR_W-1:0] FG_RESET = 3'd7;
  localparam logic [COLOR_W-1:0] BG_RESET = 3'd0;

  localparam int unsigned HELD_BIT = 5;

  typedef enum logic [1:0] {
    SET_ALPHA     = 2'd0,
    SET_CONTIG    = 2'd1,
    SET_SEPARATED = 2'd2
  } glyph_set_t;

  typedef enum logic [1:0] {
    HT_STANDARD = 2'd0,
    HT_UPPER    = 2'd1,
    HT_LOWER    = 2'd2,
    HT_BLANK    = 2'd3
  } glyph_height_t;

  typedef struct packed {
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic               mosaic;
    logic               separated;
    logic               hold;
    logic               dbl;
    logic               next_bottom;
    logic               row_bottom;
    logic [CODE_W-1:0]  held;
  } attr_t;

  typedef struct packed {
    logic [IN_DATA_W-1:0] char_code;
    logic                 row_first;
    logic                 page_first;
  } cell_t;

  typedef struct packed {
    logic [CODE_W-1:0]  glyph_code;
    glyph_set_t         glyph_set;
    glyph_height_t      glyph_height;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
    logic               is_control;
  } glyph_t;

  localparam attr_t ATTR_RESET = '{
    fg: FG_RESET, bg: BG_RESET, mosaic: 1'b0, separated: 1'b0, hold: 1'b0,
    dbl: 1'b0, next_bottom: 1'b0, row_bottom: 1'b0, held: '0
  };

endpackage

### hdl/teletext_attribute_decoder_core.sv
// Teletext serial attribute decoder: top level with input and result registers.
// One cell word per clock: a cell is captured in the input register, decoded
// against the attribute state in a single pass, and its glyph word is written
// to the result register, which drives the output, when the decode stage
// advances; a new cell is accepted every cycle while the output keeps
// draining. The rate is set by the attribute state register, which is read and
// updated once per cell in the decode stage. Control codes 0..31 update colors,
// mosaic mode, separation, height and hold as they arrive and show blank or the
// held mosaic; row_first restarts the row attributes and page_first clears the
// double-height marks.
`include "teletext_attribute_decoder_core_defines.svh"

module teletext_attribute_decoder_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [ttad_pkg::IN_DATA_W-1:0]       in_tdata,   // [7:0] char_code
  input  logic [ttad_pkg::IN_USER_W-1:0]       in_tuser,   // [0] row_first, [1] page_first
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [ttad_pkg::OUT_DATA_W-1:0]      out_tdata,  // [6:0] glyph_code,
                                                           // [8:7] glyph_set,
                                                           // [10:9] glyph_height,
                                                           // [13:11] fg_color,
                                                           // [16:14] bg_color,
                                                           // [23:17] zero
  output logic [ttad_pkg::OUT_USER_W-1:0]      out_tuser   // [0] is_control
);

  logic              cell_v_r;
  ttad_pkg::cell_t   cell_r;
  ttad_pkg::attr_t   attr_r;
  ttad_pkg::attr_t   attr_nxt;
  ttad_pkg::glyph_t  glyph_nxt;
  ttad_pkg::glyph_t  glyph_r;
  logic              out_v_r;
  logic              advance;

  assign advance   = cell_v_r && (!out_v_r || out_tready);
  assign in_tready = !cell_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_v_r <= 1'b0;
    end else if (in_tready) begin
      cell_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cell_r.char_code  <= in_tdata;
      cell_r.row_first  <= in_tuser[0];
      cell_r.page_first <= in_tuser[1];
    end
  end

  ttad_decode u_decode (
    .in_cell  (cell_r),
    .attr     (attr_r),
    .attr_nxt (attr_nxt),
    .glyph    (glyph_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ttad_pkg::ATTR_RESET;
    end else if (advance) begin
      attr_r <= attr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      out_v_r <= cell_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      glyph_r <= glyph_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, glyph_r.bg_color, glyph_r.fg_color, glyph_r.glyph_height,
                       glyph_r.glyph_set, glyph_r.glyph_code};
  assign out_tuser  = glyph_r.is_control;

  `TTAD_ASSERT_IMP(a_empty_ready, clk, rst_n, !cell_v_r, in_tready)
  `TTAD_ASSERT_NXT(a_load_shows, clk, rst_n, advance, out_tvalid)
  `TTAD_ASSERT_NXT(a_page_clears, clk, rst_n, advance && cell_r.page_first,
                   !attr_r.row_bottom)
  `TTAD_ASSERT_IMP(a_blank_code, clk, rst_n,
                   out_tvalid && out_tdata[10:9] == ttad_pkg::HT_BLANK,
                   out_tdata[6:0] == 7'd0)

endmodule

### hdl/ttad_decode.sv
// Per-cell attribute decode: next attribute state and the cell's glyph word.
module ttad_decode (
  input  ttad_pkg::cell_t  in_cell,
  input  ttad_pkg::attr_t  attr,
  output ttad_pkg::attr_t  attr_nxt,
  output ttad_pkg::glyph_t glyph
);

  logic [ttad_pkg::CODE_W-1:0] code;
  logic                        ctrl;
  ttad_pkg::attr_t             a0;
  ttad_pkg::attr_t             a1;
  logic [ttad_pkg::CODE_W-1:0] shown;
  ttad_pkg::glyph_height_t     ht;
  ttad_pkg::glyph_set_t        gset;

  assign code = in_cell.char_code[ttad_pkg::CODE_W-1:0] & ttad_pkg::CODE_MASK;
  assign ctrl = code < ttad_pkg::CODE_FIRST_CHAR;

  // row and page marks
  always_comb begin
    a0 = attr;
    if (in_cell.row_first) begin
      a0             = ttad_pkg::ATTR_RESET;
      a0.row_bottom  = attr.next_bottom;
      a0.next_bottom = 1'b0;
    end
    if (in_cell.page_first) begin
      a0.row_bottom  = 1'b0;
      a0.next_bottom = 1'b0;
    end
  end

  // control code
  always_comb begin
    a1 = a0;
    if (ctrl) begin
      if (code >= ttad_pkg::CODE_ALPHA_LO && code <= ttad_pkg::CODE_ALPHA_HI) begin
        a1.fg     = code[ttad_pkg::COLOR_W-1:0];
        a1.mosaic = 1'b0;
      end else if (code == ttad_pkg::CODE_NORMAL_HT) begin
        a1.dbl = 1'b0;
      end else if (code == ttad_pkg::CODE_DOUBLE_HT) begin
        a1.dbl = 1'b1;
        if (!a0.row_bottom) begin
          a1.next_bottom = 1'b1;
        end
      end else if (code >= ttad_pkg::CODE_MOSAIC_LO && code <= ttad_pkg::CODE_MOSAIC_HI) begin
        a1.fg     = code[ttad_pkg::COLOR_W-1:0];
        a1.mosaic = 1'b1;
      end else if (code == ttad_pkg::CODE_CONTIG) begin
        a1.separated = 1'b0;
      end else if (code == ttad_pkg::CODE_SEPARATED) begin
        a1.separated = 1'b1;
      end else if (code == ttad_pkg::CODE_BLACK_BG) begin
        a1.bg = ttad_pkg::BG_RESET;
      end else if (code == ttad_pkg::CODE_NEW_BG) begin
        a1.bg = a0.fg;
      end else if (code == ttad_pkg::CODE_HOLD_ON) begin
        a1.hold = 1'b1;
      end else if (code == ttad_pkg::CODE_HOLD_OFF) begin
        a1.hold = 1'b0;
      end
    end
  end

  always_comb begin
    if (ctrl) begin
      shown = (a1.hold && a1.mosaic) ? a1.held : '0;
    end else begin
      shown = code;
    end
    unique case ({a1.dbl, a1.row_bottom})
      2'b00:   ht = ttad_pkg::HT_STANDARD;
      2'b01:   ht = ttad_pkg::HT_BLANK;
      2'b10:   ht = ttad_pkg::HT_UPPER;
      default: ht = ttad_pkg::HT_LOWER;
    endcase
    if (!a1.mosaic) begin
      gset = ttad_pkg::SET_ALPHA;
    end else if (a1.separated) begin
      gset = ttad_pkg::SET_SEPARATED;
    end else begin
      gset = ttad_pkg::SET_CONTIG;
    end
  end

  always_comb begin
    attr_nxt = a1;
    if (a1.mosaic && shown[ttad_pkg::HELD_BIT]) begin
      attr_nxt.held = shown;
    end
  end

  assign glyph.glyph_code   = (ht == ttad_pkg::HT_BLANK) ? '0 : shown;
  assign glyph.glyph_set    = gset;
  assign glyph.glyph_height = ht;
  assign glyph.fg_color     = a1.fg;
  assign glyph.bg_color     = a1.bg;
  assign glyph.is_control   = ctrl;

endmodule
